[hw/rtl/rusi_pkg.sv]
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared widths for the ray versus unit sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rusi_pkg;

  // Payload field widths
  localparam int ORIG_W = 32;   // origin components, signed fixed point
  localparam int DIR_W  = 18;   // direction components, signed fixed point
  localparam int DIST_W = 31;   // hit distance, unsigned fixed point

  // Internal datapath widths
  localparam int L_W       = ORIG_W + 1;       // negated origin, holds +2^31
  localparam int PROD_W    = L_W + DIR_W;      // one term of L . dir
  localparam int DOT_W     = PROD_W + 2;       // sum of three terms
  localparam int LEN2_W    = 2 * ORIG_W;       // |L|^2, exact
  localparam int TCA_SAT_W = ORIG_W;           // tca at or above 2^32 saturates tca^2
  localparam int TCA_MIN_W = TCA_SAT_W + 1;    // tca keeps at least this many bits

endpackage

[hw/rtl/ray_unit_sphere_intersect.sv]
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect: ray versus unit sphere, geometric method
// Five front stages, one square-root stage per root bit, one output register.
// Throughput one transaction per cycle while out_ready does not stall the pipe;
// rst_n (sync, low) empties the pipe.
// ----------------------------------------------------------------------------
module ray_unit_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rusi_pkg::ORIG_W-1:0] in_origin_x,
  input  logic signed [rusi_pkg::ORIG_W-1:0] in_origin_y,
  input  logic signed [rusi_pkg::ORIG_W-1:0] in_origin_z,
  input  logic signed [rusi_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [rusi_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [rusi_pkg::DIR_W-1:0]  in_dir_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [rusi_pkg::DIST_W-1:0]        out_distance
);

  localparam int DW    = rusi_pkg::DOT_W;
  localparam int TCA_W = (DW - FRAC_BITS > rusi_pkg::TCA_MIN_W) ?
                         DW - FRAC_BITS : rusi_pkg::TCA_MIN_W;
  localparam int RAD_W = 2 * FRAC_BITS + 1;
  localparam int SB_W  = TCA_W + 1;

  // Front end to square root
  logic             fr_valid, fr_ready;
  logic [TCA_W-1:0] fr_tca;
  logic [RAD_W-1:0] fr_rad;
  logic             fr_miss;

  // Square root to back end
  logic               sq_valid, sq_ready;
  logic [FRAC_BITS:0] sq_root;
  logic [SB_W-1:0]    sq_sb;

  rusi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_tca     (fr_tca),
    .out_rad     (fr_rad),
    .out_miss    (fr_miss)
  );

  // tca and the miss flag ride along the square root pipeline
  rusi_sqrt #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SB_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_sb     ({fr_tca, fr_miss}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  rusi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sq_valid),
    .in_ready     (sq_ready),
    .in_tca       (sq_sb[SB_W-1:1]),
    .in_thc       (sq_root),
    .in_miss      (sq_sb[0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_distance (out_distance)
  );

endmodule

[hw/rtl/rusi_front.sv]
// ----------------------------------------------------------------------------
// rusi_front
// Five-stage front end: products, sums, tca^2, squared ray distance and
// the radicand of the half chord, plus the early miss flag.
// ----------------------------------------------------------------------------
module rusi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [rusi_pkg::ORIG_W-1:0]        in_origin_x,
  input  logic signed [rusi_pkg::ORIG_W-1:0]        in_origin_y,
  input  logic signed [rusi_pkg::ORIG_W-1:0]        in_origin_z,
  input  logic signed [rusi_pkg::DIR_W-1:0]         in_dir_x,
  input  logic signed [rusi_pkg::DIR_W-1:0]         in_dir_y,
  input  logic signed [rusi_pkg::DIR_W-1:0]         in_dir_z,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [((rusi_pkg::DOT_W - FRAC_BITS > rusi_pkg::TCA_MIN_W) ?
                 rusi_pkg::DOT_W - FRAC_BITS : rusi_pkg::TCA_MIN_W)-1:0] out_tca,
  output logic [2*FRAC_BITS:0]                      out_rad,
  output logic                                      out_miss
);

  localparam int OW    = rusi_pkg::ORIG_W;
  localparam int LW    = rusi_pkg::L_W;
  localparam int PW    = rusi_pkg::PROD_W;
  localparam int DW    = rusi_pkg::DOT_W;
  localparam int SW    = rusi_pkg::LEN2_W;
  localparam int TSW   = rusi_pkg::TCA_SAT_W;
  localparam int TCA_W = (DW - FRAC_BITS > rusi_pkg::TCA_MIN_W) ?
                         DW - FRAC_BITS : rusi_pkg::TCA_MIN_W;
  localparam int RAD_W = 2 * FRAC_BITS + 1;
  localparam logic [SW-1:0] ONE = SW'(1) << (2 * FRAC_BITS);

  // Stage enables: a stage loads when empty or when its successor moves
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en5      = ~v5_r | out_ready;
  assign en4      = ~v4_r | en5;
  assign en3      = ~v3_r | en4;
  assign en2      = ~v2_r | en3;
  assign en1      = ~v1_r | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: L = -origin, L*dir terms and squared magnitudes
  logic signed [LW-1:0] lx, ly, lz;
  logic [OW-1:0]        mag_x, mag_y, mag_z;
  logic signed [PW-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic [SW-1:0]        sqx_nxt, sqy_nxt, sqz_nxt;
  logic [SW-1:0]        sqx_r, sqy_r, sqz_r;

  assign lx = -LW'(in_origin_x);
  assign ly = -LW'(in_origin_y);
  assign lz = -LW'(in_origin_z);

  // |origin| as unsigned; the most negative code maps to 2^31
  assign mag_x = in_origin_x[OW-1] ? (~in_origin_x + OW'(1)) : in_origin_x;
  assign mag_y = in_origin_y[OW-1] ? (~in_origin_y + OW'(1)) : in_origin_y;
  assign mag_z = in_origin_z[OW-1] ? (~in_origin_z + OW'(1)) : in_origin_z;

  assign px_nxt  = lx * in_dir_x;
  assign py_nxt  = ly * in_dir_y;
  assign pz_nxt  = lz * in_dir_z;
  assign sqx_nxt = mag_x * mag_x;
  assign sqy_nxt = mag_y * mag_y;
  assign sqz_nxt = mag_z * mag_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      pz_r  <= pz_nxt;
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      sqz_r <= sqz_nxt;
    end
  end

  // Stage 2: dot product and |L|^2
  logic signed [DW-1:0] dot_nxt, dot_r;
  logic [SW-1:0]        len2_nxt, len2_r;

  assign dot_nxt  = DW'(px_r) + DW'(py_r) + DW'(pz_r);
  assign len2_nxt = sqx_r + sqy_r + sqz_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      dot_r  <= dot_nxt;
      len2_r <= len2_nxt;
    end
  end

  // Stage 3: sign test, tca and saturated tca^2
  logic [TCA_W-1:0] tca_nxt, tca3_r;
  logic [SW-1:0]    tca2_nxt, tca2_3_r, len2_3_r;
  logic             neg3_r;

  assign tca_nxt  = TCA_W'(dot_r[DW-1:FRAC_BITS]);
  assign tca2_nxt = (|tca_nxt[TCA_W-1:TSW]) ? {SW{1'b1}} :
                    (tca_nxt[TSW-1:0] * tca_nxt[TSW-1:0]);

  always_ff @(posedge clk) begin
    if (en3) begin
      neg3_r   <= dot_r[DW-1];
      tca3_r   <= tca_nxt;
      tca2_3_r <= tca2_nxt;
      len2_3_r <= len2_r;
    end
  end

  // Stage 4: squared distance, clamped at zero
  logic [SW:0]      d2_diff;
  logic [SW-1:0]    d2_nxt, d2_4_r;
  logic [TCA_W-1:0] tca4_r;
  logic             neg4_r;

  assign d2_diff = {1'b0, len2_3_r} - {1'b0, tca2_3_r};
  assign d2_nxt  = d2_diff[SW] ? '0 : d2_diff[SW-1:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      neg4_r <= neg3_r;
      tca4_r <= tca3_r;
      d2_4_r <= d2_nxt;
    end
  end

  // Stage 5: miss test and radicand one - d^2
  logic             miss_nxt, miss5_r;
  logic [SW-1:0]    rad_full;
  logic [RAD_W-1:0] rad5_r;
  logic [TCA_W-1:0] tca5_r;

  assign rad_full = ONE - d2_4_r;
  assign miss_nxt = neg4_r | (d2_4_r > ONE);

  always_ff @(posedge clk) begin
    if (en5) begin
      miss5_r <= miss_nxt;
      tca5_r  <= tca4_r;
      rad5_r  <= rad_full[RAD_W-1:0];
    end
  end

  assign out_valid = v5_r;
  assign out_tca   = tca5_r;
  assign out_rad   = rad5_r;
  assign out_miss  = miss5_r;

endmodule

[hw/rtl/rusi_sqrt.sv]
// ----------------------------------------------------------------------------
// rusi_sqrt
// Pipelined restoring integer square root, one root bit per stage, with
// a sideband word carried alongside each transaction.
// ----------------------------------------------------------------------------
module rusi_sqrt #(
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*FRAC_BITS:0]  in_rad,
  input  logic [SB_W-1:0]       in_sb,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS:0]    out_root,
  output logic [SB_W-1:0]       out_sb
);

  localparam int N     = FRAC_BITS + 1;   // root bits, one per stage
  localparam int RAD_W = 2 * FRAC_BITS + 1;
  localparam int TW    = RAD_W + 1;       // trial width

  logic [N-1:0]     v_r;
  logic [N-1:0]     en;
  logic [RAD_W-1:0] rem_r  [N];
  logic [N-1:0]     root_r [N];
  logic [SB_W-1:0]  sb_r   [N];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_stage
      localparam int BIT = N - 1 - j;

      logic [RAD_W-1:0] rem_in;
      logic [N-1:0]     root_in;
      logic [SB_W-1:0]  sb_in;
      logic             v_in;
      logic [TW-1:0]    trial;
      logic             take;
      logic [TW-1:0]    rem_sub;

      // Stage input: ports for the first stage, previous stage otherwise
      if (j == 0) begin : g_first
        assign rem_in  = in_rad;
        assign root_in = '0;
        assign sb_in   = in_sb;
        assign v_in    = in_valid;
      end else begin : g_next
        assign rem_in  = rem_r[j-1];
        assign root_in = root_r[j-1];
        assign sb_in   = sb_r[j-1];
        assign v_in    = v_r[j-1];
      end

      // Enable chain from the output side
      if (j == N - 1) begin : g_last_en
        assign en[j] = ~v_r[j] | out_ready;
      end else begin : g_mid_en
        assign en[j] = ~v_r[j] | en[j+1];
      end

      // (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT)
      assign trial   = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      assign take    = {1'b0, rem_in} >= trial;
      assign rem_sub = {1'b0, rem_in} - trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j] <= 1'b0;
        end else if (en[j]) begin
          v_r[j] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j]  <= take ? rem_sub[RAD_W-1:0] : rem_in;
          root_r[j] <= take ? (root_in | (N'(1) << BIT)) : root_in;
          sb_r[j]   <= sb_in;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

[hw/rtl/rusi_back.sv]
// ----------------------------------------------------------------------------
// rusi_back
// Picks the nearest positive root of tca -/+ thc, saturates the distance
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module rusi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [((rusi_pkg::DOT_W - FRAC_BITS > rusi_pkg::TCA_MIN_W) ?
                 rusi_pkg::DOT_W - FRAC_BITS : rusi_pkg::TCA_MIN_W)-1:0] in_tca,
  input  logic [FRAC_BITS:0]                in_thc,
  input  logic                              in_miss,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [rusi_pkg::DIST_W-1:0]       out_distance
);

  localparam int DW    = rusi_pkg::DOT_W;
  localparam int DSW   = rusi_pkg::DIST_W;
  localparam int TCA_W = (DW - FRAC_BITS > rusi_pkg::TCA_MIN_W) ?
                         DW - FRAC_BITS : rusi_pkg::TCA_MIN_W;

  logic [TCA_W-1:0] thc_ext;
  logic             near_pos;
  logic [TCA_W:0]   t_sel;
  logic             hit_nxt;
  logic [DSW-1:0]   dist_nxt;
  logic             out_valid_r, hit_r;
  logic [DSW-1:0]   dist_r;
  logic             en;

  assign thc_ext  = TCA_W'(in_thc);
  assign near_pos = in_tca > thc_ext;

  // Near root when positive, else far root; tangent at the origin misses
  assign t_sel   = near_pos ? ({1'b0, in_tca} - {1'b0, thc_ext})
                            : ({1'b0, in_tca} + {1'b0, thc_ext});
  assign hit_nxt = ~in_miss & (near_pos | (|in_tca) | (|in_thc));

  // Saturate to the largest distance code
  assign dist_nxt = ~hit_nxt ? '0 :
                    (|t_sel[TCA_W:DSW]) ? {DSW{1'b1}} : t_sel[DSW-1:0];

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_distance = dist_r;

endmodule
